// ----- sv/dmc_pkg.sv -----
// Shared constants and types for the direct-mapped cache tag model.
package dmc_pkg;

	localparam int ADDR_W         = 32;
	localparam int WORD_W         = 30;
	localparam int RECIP_W        = 31;
	localparam int LAT_W          = 8;
	localparam int STALL_W        = 10;
	localparam int CNT_W          = 32;
	localparam int LINE_COUNT_DEF = 64;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int IN_USER_W = 2;

	// m_tdata layout, lowest bit first
	localparam int HIT_BIT    = 0;
	localparam int MISS_BIT   = 1;
	localparam int WB_BIT     = 2;
	localparam int STALL_LSB  = 3;
	localparam int ACC_LSB    = STALL_LSB + STALL_W;
	localparam int HIT_T_LSB  = ACC_LSB + CNT_W;
	localparam int MISS_T_LSB = HIT_T_LSB + CNT_W;
	localparam int WB_T_LSB   = MISS_T_LSB + CNT_W;
	localparam int STALL_T_LSB = WB_T_LSB + CNT_W;
	localparam int OUT_USED_W = STALL_T_LSB + CNT_W;
	localparam int OUT_W      = ((OUT_USED_W + 7) / 8) * 8;

	localparam logic [STALL_W-1:0] CLEAN_MISS_ADD = STALL_W'(4);
	localparam logic [STALL_W-1:0] DIRTY_MISS_ADD = STALL_W'(7);

	localparam logic             CACHE_EN_RST = 1'b1;
	localparam logic             WB_MODE_RST  = 1'b1;
	localparam logic [LAT_W-1:0] MEM_LAT_RST  = LAT_W'(8);

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_PROBE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_CACHE_EN = 2'd0,
		REG_WB_MODE  = 2'd1,
		REG_MEM_LAT  = 2'd2
	} reg_idx_t;

endpackage

// ----- sv/dmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/direct_mapped_cache_tag_model.sv -----
// Direct-mapped write-back cache tag array with hit/miss statistics.
//
// Takes one access or probe word per cycle while s_tready is high and presents
// one result word per input word; each word passes stages one to four and the
// result register. The address is split into line index and tag by a two-stage
// reciprocal multiply (the line count need not be a power of two); the tag RAM
// is read in the third stage and the lookup, line update and counter update
// happen in the fourth, with a bypass for back-to-back accesses to the same
// line. After reset the block clears the tag RAM, one line per cycle; s_tready
// stays low during that pass. The whole pipeline holds while a result waits on
// m_tready. The user must write configuration through the APB port only while
// no words are in flight; the block itself does not enforce this.
module direct_mapped_cache_tag_model #(
	parameter int LINE_COUNT = dmc_pkg::LINE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dmc_pkg::ADDR_W-1:0]        s_tdata,  // address
	input  logic [dmc_pkg::IN_USER_W-1:0]     s_tuser,  // op, store
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit, miss, writeback, stall, access_total, hit_total,
	// miss_total, writeback_total, stall_total, zero pad
	output logic [dmc_pkg::OUT_W-1:0]         m_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dmc_pkg::PADDR_W-1:0]       paddr,
	input  logic [dmc_pkg::PDATA_W-1:0]       pwdata,
	output logic [dmc_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	localparam int WORD_W  = dmc_pkg::WORD_W;
	localparam int RECIP_W = dmc_pkg::RECIP_W;
	localparam int CNT_W   = dmc_pkg::CNT_W;
	localparam int STALL_W = dmc_pkg::STALL_W;
	localparam int IDX_W   = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	localparam int SHIFT   = WORD_W + $clog2(LINE_COUNT);
	localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / LINE_COUNT;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam int TAG_W   = $clog2(((64'd1 << WORD_W) - 64'd1) / LINE_COUNT + 64'd1);
	localparam int ENTRY_W = TAG_W + 2;
	localparam logic [WORD_W-1:0] LINES_W  = WORD_W'(LINE_COUNT);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(LINE_COUNT - 1);

	// configuration registers
	logic                      cache_en_q;
	logic                      wb_mode_q;
	logic [dmc_pkg::LAT_W-1:0] mem_lat_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_en_q <= dmc_pkg::CACHE_EN_RST;
			wb_mode_q  <= dmc_pkg::WB_MODE_RST;
			mem_lat_q  <= dmc_pkg::MEM_LAT_RST;
		end else if (cfg_wr) begin
			case (dmc_pkg::reg_idx_t'(paddr[3:2]))
				dmc_pkg::REG_CACHE_EN: cache_en_q <= pwdata[0];
				dmc_pkg::REG_WB_MODE:  wb_mode_q  <= pwdata[0];
				dmc_pkg::REG_MEM_LAT:  mem_lat_q  <= pwdata[dmc_pkg::LAT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (dmc_pkg::reg_idx_t'(paddr[3:2]))
			dmc_pkg::REG_CACHE_EN: prdata = dmc_pkg::PDATA_W'(cache_en_q);
			dmc_pkg::REG_WB_MODE:  prdata = dmc_pkg::PDATA_W'(wb_mode_q);
			dmc_pkg::REG_MEM_LAT:  prdata = dmc_pkg::PDATA_W'(mem_lat_q);
			default:               prdata = '0;
		endcase
	end

	// pipeline control
	logic adv;
	logic clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;

	assign adv      = !res_valid_q || m_tready;
	assign s_tready = adv && !clr_busy_q;
	assign m_tvalid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= s_tvalid && s_tready;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= v_s4;
		end
	end

	// stage 1: input register
	logic              op_s1, wr_s1;
	logic [WORD_W-1:0] word_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= s_tuser[0];
			wr_s1   <= s_tuser[1];
			word_s1 <= s_tdata[dmc_pkg::ADDR_W-1:2];
		end
	end

	// stage 2: quotient estimate, low by at most one
	logic [WORD_W+RECIP_W-1:0] prod;
	logic              op_s2, wr_s2;
	logic [WORD_W-1:0] word_s2, qest_s2;

	assign prod = word_s1 * RECIP;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			wr_s2   <= wr_s1;
			word_s2 <= word_s1;
			qest_s2 <= WORD_W'(prod >> SHIFT);
		end
	end

	// stage 3: remainder and correction give index and tag
	logic [WORD_W-1:0] rem, quo, idx_full;
	logic              op_s3, wr_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [TAG_W-1:0]  tag_s3;

	always_comb begin
		rem = word_s2 - qest_s2 * LINES_W;
		if (rem >= LINES_W) begin
			idx_full = rem - LINES_W;
			quo      = qest_s2 + WORD_W'(1);
		end else begin
			idx_full = rem;
			quo      = qest_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3  <= op_s2;
			wr_s3  <= wr_s2;
			idx_s3 <= IDX_W'(idx_full);
			tag_s3 <= TAG_W'(quo);
		end
	end

	logic               op_s4, wr_s4;
	logic [IDX_W-1:0]   idx_s4;
	logic [TAG_W-1:0]   tag_s4;
	logic               fwd_q;
	logic [ENTRY_W-1:0] fwd_data_q;

	// tag RAM: {valid, dirty, tag}
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic               upd_we;
	logic [ENTRY_W-1:0] upd_data;

	dmc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (LINE_COUNT)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv),
		.raddr (idx_s3),
		.rdata (ram_rdata)
	);

	assign ram_we    = clr_busy_q || (adv && v_s4 && upd_we);
	assign ram_waddr = clr_busy_q ? clr_idx_q : idx_s4;
	assign ram_wdata = clr_busy_q ? '0 : upd_data;

	// stage 4: lookup, line update, counters
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4      <= op_s3;
			wr_s4      <= wr_s3;
			idx_s4     <= idx_s3;
			tag_s4     <= tag_s3;
			fwd_data_q <= upd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (adv) begin
			fwd_q <= v_s4 && upd_we && v_s3 && (idx_s3 == idx_s4);
		end
	end

	logic [ENTRY_W-1:0] entry;
	logic               e_valid, e_dirty, look_hit, wr_dirty;
	logic               hit, miss, wb;
	logic [STALL_W-1:0] stall;
	logic [CNT_W-1:0]   acc_q, hit_q, miss_q, wb_q, stall_sum_q;
	logic [CNT_W-1:0]   acc_n, hit_n, miss_n, wb_n, stall_sum_n;

	assign entry    = fwd_q ? fwd_data_q : ram_rdata;
	assign e_valid  = entry[ENTRY_W-1];
	assign e_dirty  = entry[ENTRY_W-2];
	assign look_hit = e_valid && (entry[TAG_W-1:0] == tag_s4);
	assign wr_dirty = wr_s4 && wb_mode_q;

	always_comb begin
		hit         = 1'b0;
		miss        = 1'b0;
		wb          = 1'b0;
		stall       = '0;
		upd_we      = 1'b0;
		upd_data    = entry;
		acc_n       = acc_q;
		hit_n       = hit_q;
		miss_n      = miss_q;
		wb_n        = wb_q;
		stall_sum_n = stall_sum_q;
		if (!cache_en_q) begin
			hit = 1'b1;
		end else if (op_s4 == dmc_pkg::OP_PROBE) begin
			hit = look_hit;
		end else begin
			acc_n = acc_q + CNT_W'(1);
			if (look_hit) begin
				hit   = 1'b1;
				hit_n = hit_q + CNT_W'(1);
				if (wr_dirty) begin
					upd_we   = 1'b1;
					upd_data = {1'b1, 1'b1, entry[TAG_W-1:0]};
				end
			end else begin
				miss   = 1'b1;
				miss_n = miss_q + CNT_W'(1);
				if (e_valid && e_dirty && wb_mode_q) begin
					wb    = 1'b1;
					wb_n  = wb_q + CNT_W'(1);
					stall = (STALL_W'(mem_lat_q) << 1) + dmc_pkg::DIRTY_MISS_ADD;
				end else begin
					stall = STALL_W'(mem_lat_q) + dmc_pkg::CLEAN_MISS_ADD;
				end
				stall_sum_n = stall_sum_q + CNT_W'(stall);
				upd_we      = 1'b1;
				upd_data    = {1'b1, wr_dirty, tag_s4};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			wb_q        <= '0;
			stall_sum_q <= '0;
		end else if (adv && v_s4) begin
			acc_q       <= acc_n;
			hit_q       <= hit_n;
			miss_q      <= miss_n;
			wb_q        <= wb_n;
			stall_sum_q <= stall_sum_n;
		end
	end

	// result register
	logic [dmc_pkg::OUT_W-1:0] res_data_q;

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			res_data_q <= {
				(dmc_pkg::OUT_W - dmc_pkg::OUT_USED_W)'(0),
				stall_sum_n, wb_n, miss_n, hit_n, acc_n,
				stall, wb, miss, hit
			};
		end
	end

	assign m_tdata = res_data_q;

endmodule

// ----- sv/dmc_checker.sv -----
// Port-level checks for the direct-mapped cache tag model, bound to the top level.
module dmc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [dmc_pkg::OUT_W-1:0] m_tdata
);

	logic                        o_hit, o_miss, o_wb;
	logic [dmc_pkg::STALL_W-1:0] o_stall;
	logic [dmc_pkg::CNT_W-1:0]   o_acc, o_hits, o_misses;

	assign o_hit    = m_tdata[dmc_pkg::HIT_BIT];
	assign o_miss   = m_tdata[dmc_pkg::MISS_BIT];
	assign o_wb     = m_tdata[dmc_pkg::WB_BIT];
	assign o_stall  = m_tdata[dmc_pkg::STALL_LSB +: dmc_pkg::STALL_W];
	assign o_acc    = m_tdata[dmc_pkg::ACC_LSB +: dmc_pkg::CNT_W];
	assign o_hits   = m_tdata[dmc_pkg::HIT_T_LSB +: dmc_pkg::CNT_W];
	assign o_misses = m_tdata[dmc_pkg::MISS_T_LSB +: dmc_pkg::CNT_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(o_hit && o_miss) && (!o_wb || o_miss))
		else $error("inconsistent hit/miss/writeback flags");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_miss ? (o_stall != '0) : (o_stall == '0)))
		else $error("stall cycles disagree with miss flag");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (dmc_pkg::CNT_W'(o_hits + o_misses) == o_acc))
		else $error("hit and miss totals do not add up to access total");

endmodule

bind direct_mapped_cache_tag_model dmc_checker u_dmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
